/* src/imubcs_pkg.sv */
// ----------------------------------------------------------------------------
// imubcs_pkg
// Shared widths, scale constants and request types for the IMU bias
// calibration and scaling unit.
// ----------------------------------------------------------------------------
`default_nettype none

package imubcs_pkg;

  // field widths
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned NUM_AX     = 3;
  localparam int unsigned ACC_OUT_W  = 17;
  localparam int unsigned RATE_OUT_W = 18;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned SUM_W      = 32;

  // stream packing
  localparam int unsigned IN_DATA_W  = 2 * NUM_AX * RAW_W;
  localparam int unsigned OUT_USED_W = NUM_AX * (ACC_OUT_W + RATE_OUT_W);
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned RATE_OFS_BIT = NUM_AX * ACC_OUT_W;

  // serial multiplier: |d| (16 bit) times scale constant
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned K_W    = 39;
  localparam int unsigned PROD_W = MAG_W + K_W;

  // serial divider
  localparam int unsigned DIVD_W = 32;
  localparam int unsigned DIVS_W = 17;

  // accel: d * 980665 / 1600000, 1600000 = 2^9 * 3125
  localparam logic [K_W-1:0]    ACC_K    = 39'd980665;
  localparam logic [PROD_W-1:0] ACC_OFS  = 55'd800000;
  localparam int unsigned       ACC_SH   = 9;
  localparam logic [DIVS_W-1:0] ACC_DEN  = 17'd3125;

  // rate: d * 25 * pi_q32 / (72 * 2^32)
  localparam logic [K_W-1:0]    RATE_K   = 39'd337325942625;
  localparam logic [PROD_W-1:0] RATE_OFS = 55'd154618822656;
  localparam int unsigned       RATE_SH  = 32;
  localparam logic [DIVS_W-1:0] RATE_DEN = 17'd72;

  localparam logic signed [ACC_OUT_W-1:0] ONE_G = 17'sd16384;
  localparam int unsigned Z_AXIS = 2;

  localparam logic [CNT_W-1:0] COUNT_RST = 16'd100;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag;
    logic [K_W-1:0]   k;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* src/imubcs_mul.sv */
// ----------------------------------------------------------------------------
// imubcs_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module imubcs_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imubcs_pkg::mul_req_t req_i,
  output imubcs_pkg::mul_rsp_t rsp_o
);

  localparam int unsigned MW  = imubcs_pkg::MAG_W;
  localparam int unsigned KW  = imubcs_pkg::K_W;
  localparam int unsigned PW  = imubcs_pkg::PROD_W;
  localparam int unsigned CW  = $clog2(MW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [MW-1:0] m_q;
  logic [KW-1:0] k_q;
  logic [PW-1:0] acc_q;
  logic [PW-1:0] acc_d;

  assign acc_d = {acc_q[PW-2:0], 1'b0} + (m_q[MW-1] ? PW'(k_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      m_q   <= req_i.mag;
      k_q   <= req_i.k;
    end else if (busy_q) begin
      acc_q <= acc_d;
      m_q   <= {m_q[MW-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

/* src/imubcs_div.sv */
// ----------------------------------------------------------------------------
// imubcs_div
// Restoring radix-2 divider: one quotient bit per cycle shifted into the
// dividend register.
// ----------------------------------------------------------------------------
`default_nettype none

module imubcs_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imubcs_pkg::div_req_t req_i,
  output imubcs_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NW = imubcs_pkg::DIVD_W;
  localparam int unsigned DW = imubcs_pkg::DIVS_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] dvd_q;
  logic [DW-1:0] dvs_q;
  logic [DW-1:0] rem_q;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, dvd_q[NW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      dvd_q <= {dvd_q[NW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

`default_nettype wire

/* src/imu_bias_calibrate_and_scale_unit.sv */
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_scale_unit
// Six-axis IMU bias calibration (averaging) and conversion of raw words to
// fixed-point acceleration and angular rate.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: operation, tdata: raw words
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tuser: result_kind, tdata: results
//  cfg      | in  | cfg_valid_i / cfg_ready_o     | cfg_data_i: sample_count
//
//  One item at a time; channels are handled one after another through a
//  shared serial multiplier and serial divider. A convert item runs one
//  multiplication and one division per channel; a calibration sample adds
//  to the sums, and the closing one divides each sum by the samples summed.
//  A finished result waits in the output register; the next item is taken
//  while it waits. Reset clears sums and biases and sets the sample count to 100.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_bias_calibrate_and_scale_unit #(
  parameter int unsigned AXES = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] acc_x_raw, [31:16] acc_y_raw, [47:32] acc_z_raw,
  // [63:48] rate_x_raw, [79:64] rate_y_raw, [95:80] rate_z_raw
  input  logic [imubcs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] operation
  input  logic                                 s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [16:0] acc_x_out, [33:17] acc_y_out, [50:34] acc_z_out,
  // [68:51] rate_x_out, [86:69] rate_y_out, [104:87] rate_z_out, rest zero
  output logic [imubcs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] result_kind
  output logic                                 m_axis_tuser,
  // sample_count register write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [imubcs_pkg::CNT_W-1:0]         cfg_data_i
);

  localparam int unsigned AX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned RW   = imubcs_pkg::RAW_W;
  localparam int unsigned AW   = imubcs_pkg::ACC_OUT_W;
  localparam int unsigned QW   = imubcs_pkg::RATE_OUT_W;
  localparam int unsigned SW   = imubcs_pkg::SUM_W;
  localparam int unsigned NA   = imubcs_pkg::NUM_AX;
  localparam int unsigned DSW  = imubcs_pkg::DIVS_W;
  localparam int unsigned DDW  = imubcs_pkg::DIVD_W;
  localparam int unsigned PW   = imubcs_pkg::PROD_W;
  localparam int unsigned CNW  = imubcs_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CAL_GO,
    ST_CAL_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic [AX_W-1:0]  ax_q;
  logic             sel_q;      // 0 accel, 1 gyro
  logic             sign_q;
  logic [CNW-1:0]   seen_q;
  logic [CNW-1:0]   count_q;
  logic             kind_q;
  logic             m_tvalid_q;
  logic             m_tuser_q;

  logic [SW-1:0]    acc_sum_q   [AXES];
  logic [SW-1:0]    rate_sum_q  [AXES];
  logic [RW-1:0]    acc_bias_q  [AXES];
  logic [RW-1:0]    rate_bias_q [AXES];
  logic [RW-1:0]    raw_acc_q   [AXES];
  logic [RW-1:0]    raw_rate_q  [AXES];
  logic [AW-1:0]    res_acc_q   [AXES];
  logic [QW-1:0]    res_rate_q  [AXES];
  logic [AW-1:0]    out_acc_q   [AXES];
  logic [QW-1:0]    out_rate_q  [AXES];

  imubcs_pkg::mul_req_t mul_req;
  imubcs_pkg::mul_rsp_t mul_rsp;
  imubcs_pkg::div_req_t div_req;
  imubcs_pkg::div_rsp_t div_rsp;

  logic             in_acc;
  logic             out_load;
  logic             last_ch;
  logic [AX_W-1:0]  ax_nxt;
  logic             sel_nxt;
  logic [DSW-1:0]   n17;
  logic [RW-1:0]    raw_sel;
  logic [RW-1:0]    bias_sel;
  logic [SW-1:0]    sum_sel;
  logic [SW-1:0]    cal_mag;
  logic [AW-1:0]    d17;
  logic [AW-1:0]    d_abs;
  logic [PW-1:0]    prod_ofs;
  logic [DDW-1:0]   cnv_dvd;
  logic [AW-1:0]    q_cal;
  logic [AW-1:0]    b_cal;
  logic [AW-1:0]    z_cal;
  logic [RW-1:0]    bias_new;
  logic [QW-1:0]    q_cnv;
  logic [QW-1:0]    r_cnv;
  logic             is_z_acc;

  // --------------------------------------------------------------------------
  // handshakes and channel sequencing
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!m_tvalid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  assign last_ch = (ax_q == AX_W'(AXES - 1)) && sel_q;
  assign sel_nxt = last_ch ? 1'b0 : !sel_q;
  assign ax_nxt  = last_ch ? '0 : (sel_q ? ax_q + AX_W'(1) : ax_q);

  assign n17 = {1'b0, seen_q} + DSW'(1);

  // --------------------------------------------------------------------------
  // operand selection for the current channel
  // --------------------------------------------------------------------------
  assign raw_sel  = sel_q ? raw_rate_q[ax_q]  : raw_acc_q[ax_q];
  assign bias_sel = sel_q ? rate_bias_q[ax_q] : acc_bias_q[ax_q];
  assign sum_sel  = sel_q ? rate_sum_q[ax_q]  : acc_sum_q[ax_q];

  assign cal_mag = sum_sel[SW-1] ? (SW'(0) - sum_sel) : sum_sel;

  assign d17   = {raw_sel[RW-1], raw_sel} - {bias_sel[RW-1], bias_sel};
  assign d_abs = d17[AW-1] ? (AW'(0) - d17) : d17;

  // round-to-nearest offset, then the power-of-two part of the divisor
  assign prod_ofs = mul_rsp.prod + (sel_q ? imubcs_pkg::RATE_OFS : imubcs_pkg::ACC_OFS);
  assign cnv_dvd  = sel_q ? DDW'(prod_ofs >> imubcs_pkg::RATE_SH)
                          : DDW'(prod_ofs >> imubcs_pkg::ACC_SH);

  always_comb begin
    mul_req       = '0;
    mul_req.mag   = d_abs[imubcs_pkg::MAG_W-1:0];
    mul_req.k     = sel_q ? imubcs_pkg::RATE_K : imubcs_pkg::ACC_K;
    mul_req.start = (state_q == ST_MUL_GO);
  end

  always_comb begin
    div_req = '0;
    case (state_q)
      ST_CAL_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = cal_mag;
        div_req.divisor  = n17;
      end
      ST_MUL_WAIT: begin
        div_req.start    = mul_rsp.done;
        div_req.dividend = cnv_dvd;
        div_req.divisor  = sel_q ? imubcs_pkg::RATE_DEN : imubcs_pkg::ACC_DEN;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // result forming
  // --------------------------------------------------------------------------
  assign is_z_acc = (AXES == NA) && !sel_q && (ax_q == AX_W'(imubcs_pkg::Z_AXIS));

  // truncating average, sign restored; z accel gets +1 g, saturated
  assign q_cal = div_rsp.quotient[AW-1:0];
  assign b_cal = sign_q ? (AW'(0) - q_cal) : q_cal;
  assign z_cal = {b_cal[RW-1], b_cal[RW-1:0]} + imubcs_pkg::ONE_G;

  always_comb begin
    bias_new = b_cal[RW-1:0];
    if (is_z_acc) begin
      bias_new = (z_cal[AW-1:RW-1] == 2'b01) ? {1'b0, {(RW-1){1'b1}}} : z_cal[RW-1:0];
    end
  end

  assign q_cnv = div_rsp.quotient[QW-1:0];
  assign r_cnv = sign_q ? (QW'(0) - q_cnv) : q_cnv;

  // --------------------------------------------------------------------------
  // control FSM and output handshake
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ax_q       <= '0;
      sel_q      <= 1'b0;
      sign_q     <= 1'b0;
      seen_q     <= '0;
      count_q    <= imubcs_pkg::COUNT_RST;
      kind_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
      m_tuser_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (out_load) begin
        m_tvalid_q <= 1'b1;
        m_tuser_q  <= kind_q;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            ax_q    <= '0;
            sel_q   <= 1'b0;
            state_q <= s_axis_tuser ? ST_SUM : ST_MUL_GO;
          end
        end
        ST_SUM: begin
          ax_q  <= ax_nxt;
          sel_q <= sel_nxt;
          if (last_ch) begin
            if (n17 >= {1'b0, count_q}) begin
              state_q <= ST_CAL_GO;
            end else begin
              seen_q  <= n17[CNW-1:0];
              state_q <= ST_IDLE;
            end
          end
        end
        ST_CAL_GO: begin
          sign_q  <= sum_sel[SW-1];
          state_q <= ST_CAL_WAIT;
        end
        ST_CAL_WAIT: begin
          if (div_rsp.done) begin
            ax_q  <= ax_nxt;
            sel_q <= sel_nxt;
            if (last_ch) begin
              seen_q  <= '0;
              kind_q  <= 1'b1;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_CAL_GO;
            end
          end
        end
        ST_MUL_GO: begin
          sign_q  <= d17[AW-1];
          state_q <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mul_rsp.done) begin
            state_q <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            ax_q  <= ax_nxt;
            sel_q <= sel_nxt;
            if (last_ch) begin
              kind_q  <= 1'b0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_MUL_GO;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // running sums and biases
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        acc_sum_q[a]   <= '0;
        rate_sum_q[a]  <= '0;
        acc_bias_q[a]  <= '0;
        rate_bias_q[a] <= '0;
      end
    end else begin
      if (state_q == ST_SUM) begin
        if (sel_q) begin
          rate_sum_q[ax_q] <= rate_sum_q[ax_q] + {{(SW-RW){raw_sel[RW-1]}}, raw_sel};
        end else begin
          acc_sum_q[ax_q] <= acc_sum_q[ax_q] + {{(SW-RW){raw_sel[RW-1]}}, raw_sel};
        end
      end
      if ((state_q == ST_CAL_WAIT) && div_rsp.done) begin
        if (sel_q) begin
          rate_bias_q[ax_q] <= bias_new;
          rate_sum_q[ax_q]  <= '0;
        end else begin
          acc_bias_q[ax_q] <= bias_new;
          acc_sum_q[ax_q]  <= '0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sample latch, result staging, output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int a = 0; a < AXES; a++) begin
        raw_acc_q[a]  <= s_axis_tdata[a*RW +: RW];
        raw_rate_q[a] <= s_axis_tdata[(NA+a)*RW +: RW];
      end
    end
    if ((state_q == ST_CAL_WAIT) && div_rsp.done) begin
      if (sel_q) begin
        res_rate_q[ax_q] <= {{(QW-RW){bias_new[RW-1]}}, bias_new};
      end else begin
        res_acc_q[ax_q] <= {{(AW-RW){bias_new[RW-1]}}, bias_new};
      end
    end
    if ((state_q == ST_DIV_WAIT) && div_rsp.done) begin
      if (sel_q) begin
        res_rate_q[ax_q] <= r_cnv;
      end else begin
        res_acc_q[ax_q] <= r_cnv[AW-1:0];
      end
    end
    if (out_load) begin
      for (int a = 0; a < AXES; a++) begin
        out_acc_q[a]  <= res_acc_q[a];
        out_rate_q[a] <= res_rate_q[a];
      end
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_pack
    if (a < AXES) begin : g_used
      assign m_axis_tdata[a*AW +: AW] = out_acc_q[a];
      assign m_axis_tdata[imubcs_pkg::RATE_OFS_BIT + a*QW +: QW] = out_rate_q[a];
    end else begin : g_unused
      assign m_axis_tdata[a*AW +: AW] = '0;
      assign m_axis_tdata[imubcs_pkg::RATE_OFS_BIT + a*QW +: QW] = '0;
    end
  end
  if (imubcs_pkg::OUT_DATA_W > imubcs_pkg::OUT_USED_W) begin : g_pad
    assign m_axis_tdata[imubcs_pkg::OUT_DATA_W-1:imubcs_pkg::OUT_USED_W] = '0;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tuser  = m_tuser_q;

  // --------------------------------------------------------------------------
  // serial arithmetic units
  // --------------------------------------------------------------------------
  imubcs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  imubcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_mul_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == ST_MUL_WAIT))
    else $error("multiplier finished outside its wait state");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == ST_DIV_WAIT) || (state_q == ST_CAL_WAIT)))
    else $error("divider finished outside a wait state");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_OUT) && m_tvalid_q && !m_axis_tready) |=>
      ((state_q == ST_OUT) && m_tvalid_q))
    else $error("staged result overwrote a pending output");

  a_seen_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && kind_q) |-> (seen_q == '0))
    else $error("bias result issued with samples still counted");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the IMU bias calibration and scaling unit. A queue fed
// driver offers raw six-axis samples, a clocked monitor predicts the biases
// and the scaled acceleration/rate for each accepted request and compares the
// results field by field. Directed corner cases come first, then random
// phases over several sample_count settings and idle/stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned NUM_AX       = imubcs_pkg::NUM_AX;
  localparam int unsigned RAW_W        = imubcs_pkg::RAW_W;
  localparam int unsigned SUM_W        = imubcs_pkg::SUM_W;
  localparam int unsigned CNT_W        = imubcs_pkg::CNT_W;
  localparam int unsigned IN_DATA_W    = imubcs_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W   = imubcs_pkg::OUT_DATA_W;
  localparam int unsigned OUT_USED_W   = imubcs_pkg::OUT_USED_W;
  localparam int unsigned ACC_OUT_W    = imubcs_pkg::ACC_OUT_W;
  localparam int unsigned RATE_OUT_W   = imubcs_pkg::RATE_OUT_W;
  localparam int unsigned RATE_OFS_BIT = imubcs_pkg::RATE_OFS_BIT;
  localparam logic [CNT_W-1:0] COUNT_RST = imubcs_pkg::COUNT_RST;

  localparam int unsigned AXES          = NUM_AX;
  localparam int unsigned RANDOM_ITEMS  = 1550;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;

  localparam longint unsigned ACCEL_MUL = 64'd980665;
  localparam longint unsigned ACCEL_DIV = 64'd1600000;
  localparam longint unsigned GYRO_MUL  = 64'd25 * 64'd13493037705;
  localparam longint unsigned GYRO_DIV  = 64'd72 << 32;
  localparam int GRAVITY_LSB = 16384;
  localparam int BIAS_MAX    = 32767;

  localparam logic OP_CONVERT       = 1'b0;
  localparam logic OP_CALIBRATE     = 1'b1;
  localparam logic KIND_MEASUREMENT = 1'b0;
  localparam logic KIND_BIASES      = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [IN_DATA_W-1:0] raw;
  } imu_sample_t;

  typedef struct packed {
    logic                  kind;
    logic [OUT_DATA_W-1:0] data;
  } imu_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CNT_W-1:0]      cfg_data_i = '0;

  imu_bias_calibrate_and_scale_unit #(
    .AXES(AXES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  imu_sample_t sample_q[$];
  imu_result_t imu_result_q[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_requests   = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  int samples_pushed  = 0;
  int samples_taken   = 0;
  int mismatches      = 0;
  int cycle_count     = 0;

  // mirror of the unit's calibration state
  logic [CNT_W-1:0] sample_count_q;
  logic [CNT_W-1:0] samples_seen;
  logic [SUM_W-1:0] acc_sum  [NUM_AX];
  logic [SUM_W-1:0] rate_sum [NUM_AX];
  int               acc_bias [NUM_AX];
  int               rate_bias[NUM_AX];

  logic [RAW_W-1:0] axis_center[2*NUM_AX];

  // round to nearest, ties away from zero, of d * mult / divisor
  function automatic longint round_scaled(longint d, longint unsigned mult,
                                          longint unsigned divisor);
    longint unsigned m;
    longint unsigned q;
    m = (d < 0) ? $unsigned(-d) : $unsigned(d);
    q = (m * mult + divisor / 2) / divisor;
    return (d < 0) ? -$signed(q) : $signed(q);
  endfunction

  // signed sum divided by n, truncated toward zero
  function automatic int sum_average(logic [SUM_W-1:0] sum, int unsigned n);
    longint s;
    longint m;
    s = longint'($signed(sum));
    m = (s < 0) ? -s : s;
    m = m / longint'(n);
    return (s < 0) ? int'(-m) : int'(m);
  endfunction

  task automatic imu_compute(input imu_sample_t s, output bit has_out,
                             output imu_result_t r);
    logic signed [RAW_W-1:0] acc_raw [NUM_AX];
    logic signed [RAW_W-1:0] rate_raw[NUM_AX];
    int unsigned n;
    longint      v;
    int          i;
    r = '0;
    has_out = 1'b1;
    for (i = 0; i < NUM_AX; i++) begin
      acc_raw[i]  = s.raw[i*RAW_W +: RAW_W];
      rate_raw[i] = s.raw[(NUM_AX+i)*RAW_W +: RAW_W];
    end
    if (s.op == OP_CALIBRATE) begin
      n = samples_seen + 1;
      for (i = 0; i < AXES; i++) begin
        acc_sum[i]  = acc_sum[i] + {{(SUM_W-RAW_W){acc_raw[i][RAW_W-1]}}, acc_raw[i]};
        rate_sum[i] = rate_sum[i] + {{(SUM_W-RAW_W){rate_raw[i][RAW_W-1]}}, rate_raw[i]};
      end
      if (n < sample_count_q) begin
        samples_seen = n[CNT_W-1:0];
        has_out = 1'b0;
        return;
      end
      for (i = 0; i < AXES; i++) begin
        acc_bias[i]  = sum_average(acc_sum[i], n);
        rate_bias[i] = sum_average(rate_sum[i], n);
      end
      // 1 g on z, saturated high only
      if (AXES > 2) begin
        acc_bias[2] = acc_bias[2] + GRAVITY_LSB;
        if (acc_bias[2] > BIAS_MAX) acc_bias[2] = BIAS_MAX;
      end
      for (i = 0; i < NUM_AX; i++) begin
        acc_sum[i]  = '0;
        rate_sum[i] = '0;
      end
      samples_seen = '0;
      r.kind = KIND_BIASES;
      for (i = 0; i < AXES; i++) begin
        r.data[i*ACC_OUT_W +: ACC_OUT_W] = acc_bias[i][ACC_OUT_W-1:0];
        r.data[RATE_OFS_BIT + i*RATE_OUT_W +: RATE_OUT_W] = rate_bias[i][RATE_OUT_W-1:0];
      end
    end else begin
      r.kind = KIND_MEASUREMENT;
      for (i = 0; i < AXES; i++) begin
        v = round_scaled(longint'(acc_raw[i]) - acc_bias[i], ACCEL_MUL, ACCEL_DIV);
        r.data[i*ACC_OUT_W +: ACC_OUT_W] = v[ACC_OUT_W-1:0];
        v = round_scaled(longint'(rate_raw[i]) - rate_bias[i], GYRO_MUL, GYRO_DIV);
        r.data[RATE_OFS_BIT + i*RATE_OUT_W +: RATE_OUT_W] = v[RATE_OUT_W-1:0];
      end
    end
  endtask

  task automatic check_field(string name, int axis, logic [17:0] want, logic [17:0] got);
    if (want !== got) begin
      $display("%0t: %s[%0d] mismatch: expected %h, got %h", $time, name, axis, want, got);
      mismatches++;
    end
  endtask

  // driver: one request held until taken, then the next from the queue
  always @(posedge clk_i) begin : sample_driver
    imu_sample_t next_item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_item = sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_item.raw;
        s_axis_tuser  <= next_item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: checks results, predicts accepted requests, drives tready
  always @(posedge clk_i) begin : result_monitor
    imu_sample_t seen;
    imu_result_t want;
    bit          has_out;
    int          i;
    if (!rst_ni) begin
      m_axis_tready  <= 1'b0;
      sample_count_q = COUNT_RST;
      samples_seen   = '0;
      for (i = 0; i < NUM_AX; i++) begin
        acc_sum[i]   = '0;
        rate_sum[i]  = '0;
        acc_bias[i]  = 0;
        rate_bias[i] = 0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (imu_result_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0d data %h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = imu_result_q.pop_front();
          check_field("kind", 0, 18'(want.kind), 18'(m_axis_tuser));
          for (i = 0; i < NUM_AX; i++) begin
            check_field("acc", i, 18'(want.data[i*ACC_OUT_W +: ACC_OUT_W]),
                        18'(m_axis_tdata[i*ACC_OUT_W +: ACC_OUT_W]));
            check_field("rate", i, want.data[RATE_OFS_BIT + i*RATE_OUT_W +: RATE_OUT_W],
                        m_axis_tdata[RATE_OFS_BIT + i*RATE_OUT_W +: RATE_OUT_W]);
          end
          check_field("pad", 0, 18'(want.data[OUT_DATA_W-1:OUT_USED_W]),
                      18'(m_axis_tdata[OUT_DATA_W-1:OUT_USED_W]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen.op  = s_axis_tuser;
        seen.raw = s_axis_tdata;
        imu_compute(seen, has_out, want);
        if (has_out) imu_result_q.push_back(want);
        samples_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) sample_count_q = cfg_data_i;

      if (holds_served != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL imu_bias_calibrate_and_scale_unit");
      $finish;
    end
  end

  function automatic logic [RAW_W-1:0] sample_word();
    case ($urandom_range(19))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] near_word(logic [RAW_W-1:0] c);
    return RAW_W'(c + $urandom_range(256) - 128);
  endfunction

  task automatic push_sample(logic op, logic [IN_DATA_W-1:0] raw);
    sample_q.push_back({op, raw});
    samples_pushed++;
  endtask

  // a stationary-sensor run: values cluster around fresh per-axis offsets
  task automatic push_calib_run(int count);
    logic [IN_DATA_W-1:0] raw;
    int i;
    int a;
    for (a = 0; a < 2*NUM_AX; a++) begin
      if (a == 2) axis_center[a] = $urandom_range(1) ? 16'h4000 : 16'hC000;
      else        axis_center[a] = RAW_W'($urandom_range(40000) - 20000);
    end
    for (i = 0; i < count; i++) begin
      for (a = 0; a < 2*NUM_AX; a++)
        raw[a*RAW_W +: RAW_W] = ($urandom_range(9) < 8) ? near_word(axis_center[a])
                                                        : sample_word();
      push_sample(OP_CALIBRATE, raw);
    end
  endtask

  task automatic push_convert_run(int count);
    logic [IN_DATA_W-1:0] raw;
    int i;
    int a;
    for (i = 0; i < count; i++) begin
      for (a = 0; a < 2*NUM_AX; a++)
        raw[a*RAW_W +: RAW_W] = $urandom_range(1) ? near_word(axis_center[a]) : sample_word();
      push_sample(OP_CONVERT, raw);
    end
  endtask

  // all requests taken, all results back, then room for a silent closing step
  task automatic drain_results();
    do @(posedge clk_i);
    while (samples_taken != samples_pushed || imu_result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sample_count(logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int ph;
    int rnd;
    int made;
    int count;
    int a;
    made = 0;
    for (a = 0; a < 2*NUM_AX; a++) axis_center[a] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero biases, raw extremes and alternating bit patterns
    push_sample(OP_CONVERT, '0);
    push_sample(OP_CONVERT, {6{16'h7FFF}});
    push_sample(OP_CONVERT, {6{16'h8000}});
    push_sample(OP_CONVERT, {16'h0002, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF});
    push_sample(OP_CONVERT, {3{16'h5555, 16'hAAAA}});
    drain_results();

    // one-sample calibration at both rails, z bias saturates high
    write_sample_count(16'd1);
    push_sample(OP_CALIBRATE, {6{16'h7FFF}});
    push_sample(OP_CONVERT, {6{16'h8000}});
    push_sample(OP_CONVERT, {6{16'h7FFF}});
    push_sample(OP_CALIBRATE, {6{16'h8000}});
    push_sample(OP_CONVERT, {6{16'h7FFF}});
    drain_results();

    // a count of zero behaves as one
    write_sample_count(16'd0);
    push_sample(OP_CALIBRATE, {16'h0005, 16'hFFB3, 16'h004D, 16'h0000, 16'hFC18, 16'h03E8});
    push_sample(OP_CONVERT, {16'h1234, 16'hEDCB, 16'h0FF0, 16'h4000, 16'hC000, 16'h0001});
    drain_results();

    // three samples: small negative sums truncate toward zero
    write_sample_count(16'd3);
    push_sample(OP_CALIBRATE, {16'h0001, 16'h7FFF, 16'h8000, 16'hFFFB, 16'h0005, 16'hFFFF});
    push_sample(OP_CALIBRATE, {16'h0001, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF});
    push_sample(OP_CALIBRATE, {16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000});
    push_sample(OP_CONVERT, '0);
    push_sample(OP_CONVERT, {16'hC000, 16'h4000, 16'h0123, 16'h4000, 16'h8001, 16'h7FFE});
    drain_results();

    for (ph = 0; made < RANDOM_ITEMS; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin sender_idle_pct <= 52; recv_stall_pct <= 0;  end
        2: begin sender_idle_pct <= 0;  recv_stall_pct <= 52; end
        default: begin sender_idle_pct <= 21; recv_stall_pct <= 21; end
      endcase
      case (ph % 10)
        0: count = 100;
        1: count = 1;
        2: count = 0;
        3: count = 65535;
        4: count = 7;
        5: count = 2;
        6: count = 40;
        7: count = 3;
        8: count = 16;
        default: count = 1;
      endcase
      write_sample_count(CNT_W'(count));
      if (count == 65535) begin
        // lowering the count below the samples already summed closes early
        push_calib_run(40);
        made += 40;
        drain_results();
        count = 6;
        write_sample_count(CNT_W'(count));
      end
      for (rnd = 0; rnd < 2; rnd++) begin
        a = $urandom_range(15, 45);
        push_convert_run(a);
        made += a;
        // long receiver hold while requests keep coming
        if (ph % 4 == 0 && rnd == 0) hold_requests <= hold_requests + 1;
        a = (count == 0) ? 1 : count;
        push_calib_run(a);
        made += a;
        if (ph % 4 == 1 && rnd == 0) drain_results();
      end
      drain_results();
    end

    drain_results();
    if (mismatches == 0 && imu_result_q.size() == 0) begin
      $display("PASS imu_bias_calibrate_and_scale_unit");
    end else begin
      $display("FAIL imu_bias_calibrate_and_scale_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* imu_bias_calibrate_and_scale_unit.f */
src/imubcs_pkg.sv
src/imubcs_mul.sv
src/imubcs_div.sv
src/imu_bias_calibrate_and_scale_unit.sv
tb/sv/tb_top.sv
